[sv/uhnt_pkg.sv]
// ----------------------------------------------------------------------------
// uhnt_pkg
// Shared types and codes for the hashed identifier table: operation and
// status codes, register indexes, controller states and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package uhnt_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int BUCKETS_DEF = 1024;

  localparam logic [31:0] ID_BASE_RESET = 32'd100;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_INSTALL = 3'd1;
  localparam logic [2:0] OP_LOOKUP  = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_INUSE    = 2'd3;

  localparam logic CFG_LOCAL_NODE = 1'b0;
  localparam logic CFG_ID_BASE    = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_HCHK,
    S_BRD,
    S_BHEAD,
    S_WSTEP,
    S_WCMP,
    S_INS,
    S_DETACH,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    WE_NONE,
    WE_INSERT,
    WE_LOOKUP,
    WE_RELEASE,
    WE_PREV,
    WE_DETACH
  } ent_wr_t;

  typedef enum logic [1:0] {
    BK_NONE,
    BK_INSERT,
    BK_UNLINK
  } bkt_wr_t;

  typedef struct packed {
    logic       clr_step;
    logic       take;
    logic       keep_cur;
    logic       key_alloc;
    logic       key_entry;
    logic       rd_p;
    logic       walk_start;
    logic       walk_adv;
    ent_wr_t    ent_wr;
    bkt_wr_t    bkt_wr;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_found;
    logic       res_given;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [2:0] op;
    logic       h_ok;
    logic       key_zero;
    logic       cur_assigned;
    logic       cur_inuse;
    logic       walk_end;
    logic       match;
    logic       prev_nil;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/uid_hash_name_table.sv]
// ----------------------------------------------------------------------------
// uid_hash_name_table
// Hashed table of unique identifiers with chain links and reference counts.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  op, port_handle, uid_origin, uid_serial
//  out      out_valid/out_ready  status, found_handle, assigned_serial
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  After reset a sweep clears the bucket and entry RAMs; no word is taken
//  meanwhile, configuration is. One operation at a time: early answers skip
//  the chain walk; otherwise the bucket head is read and, for all but alloc,
//  the chain is walked one entry at a time through the single read port of
//  the entry RAM.
//  A result waits in the output register; the next word is taken while it
//  waits, and the controller holds in its final state until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module uid_hash_name_table #(
  parameter int ENTRIES = uhnt_pkg::ENTRIES_DEF,
  parameter int BUCKETS = uhnt_pkg::BUCKETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [7:0]  port_handle,
  input  wire logic [15:0] uid_origin,
  input  wire logic [31:0] uid_serial,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       found_handle,
  output logic [31:0]      assigned_serial,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  import uhnt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  uhnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uhnt_dp #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .port_handle     (port_handle),
    .uid_origin      (uid_origin),
    .uid_serial      (uid_serial),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .found_handle    (found_handle),
    .assigned_serial (assigned_serial),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

[sv/uhnt_ram.sv]
// ----------------------------------------------------------------------------
// uhnt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module uhnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/uhnt_dp.sv]
// ----------------------------------------------------------------------------
// uhnt_dp
// Datapath: bucket head and entry RAMs, item and key registers, chain walk
// pointers, serial counter, configuration and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uhnt_dp #(
  parameter int ENTRIES = 256,
  parameter int BUCKETS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        op,
  input  wire logic [7:0]        port_handle,
  input  wire logic [15:0]       uid_origin,
  input  wire logic [31:0]       uid_serial,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [7:0]             found_handle,
  output logic [31:0]            assigned_serial,
  input  wire uhnt_pkg::dp_cmd_t cmd,
  output uhnt_pkg::dp_sts_t      sts
);

  import uhnt_pkg::*;

  localparam int EW    = $clog2(ENTRIES);
  localparam int LW    = $clog2(ENTRIES + 1);
  localparam int BW    = $clog2(BUCKETS);
  localparam int WW    = 64 + LW;
  localparam int CLR_N = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [LW-1:0] NIL      = LW'(ENTRIES);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

  logic [2:0]    op_q;
  logic [7:0]    h_q;
  logic [15:0]   org_q;
  logic [31:0]   ser_q;
  logic [WW-1:0] cur;
  logic [WW-1:0] pw;
  logic [LW-1:0] p;
  logic [LW-1:0] prev;
  logic [LW-1:0] head;
  logic [LW-1:0] steps;
  logic [31:0]   serial_count;
  logic [15:0]   local_node;
  logic [31:0]   id_base;
  logic [CW-1:0] clr_cnt;
  logic          clr_done;
  logic [1:0]    res_status;
  logic [7:0]    res_found;
  logic [31:0]   res_given;

  logic [WW-1:0] ent_rdata;
  logic [LW-1:0] bkt_rdata;
  logic          ent_we;
  logic [EW-1:0] ent_waddr;
  logic [WW-1:0] ent_wdata;
  logic [EW-1:0] ent_raddr;
  logic          bkt_we;
  logic [BW-1:0] bkt_waddr;
  logic [LW-1:0] bkt_wdata;

  logic [EW+7:0] h_wide;
  logic [EW-1:0] hidx;
  logic [LW-1:0] hlink;
  logic [31:0]   key_sum;
  logic [BW-1:0] bidx;
  logic [LW+7:0] p_wide;

  logic [15:0]   rd_org;
  logic [31:0]   rd_ser;
  logic [15:0]   rd_refs;
  logic [LW-1:0] rd_next;
  logic [15:0]   cur_refs;
  logic [15:0]   refs_inc;
  logic [15:0]   refs_dec;

  logic [31:0]   s_max;
  logic [31:0]   s_inc;
  logic [31:0]   s_new;

  assign h_wide  = {{EW{1'b0}}, h_q};
  assign hidx    = h_wide[EW-1:0];
  assign hlink   = LW'(hidx);
  assign key_sum = {16'd0, org_q} + ser_q;
  assign bidx    = key_sum[BW-1:0];
  assign p_wide  = {8'd0, p};

  assign rd_org   = ent_rdata[WW-1 -: 16];
  assign rd_ser   = ent_rdata[WW-17 -: 32];
  assign rd_refs  = ent_rdata[LW+15:LW];
  assign rd_next  = ent_rdata[LW-1:0];
  assign cur_refs = cur[LW+15:LW];
  assign refs_inc = (rd_refs == 16'hFFFF) ? rd_refs : rd_refs + 16'd1;
  assign refs_dec = (rd_refs == 16'd0) ? rd_refs : rd_refs - 16'd1;

  assign s_max = (serial_count > id_base) ? serial_count : id_base;
  assign s_inc = s_max + 32'd1;
  assign s_new = (s_inc == 32'd0) ? 32'd1 : s_inc;

  assign ent_raddr = cmd.rd_p ? p[EW-1:0] : hidx;

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = hidx;
    ent_wdata = cur;
    if (cmd.clr_step) begin
      ent_we    = ({{(32-CW){1'b0}}, clr_cnt} < 32'(ENTRIES));
      ent_waddr = clr_cnt[EW-1:0];
      ent_wdata = {16'd0, 32'd0, 16'd0, NIL};
    end else begin
      unique case (cmd.ent_wr)
        WE_INSERT: begin
          ent_we    = 1'b1;
          ent_wdata = {org_q, ser_q, cur_refs, head};
        end
        WE_LOOKUP: begin
          ent_we    = 1'b1;
          ent_waddr = p[EW-1:0];
          ent_wdata = {rd_org, rd_ser, refs_inc, rd_next};
        end
        WE_RELEASE: begin
          ent_we    = 1'b1;
          ent_wdata = {rd_org, rd_ser, refs_dec, rd_next};
        end
        WE_PREV: begin
          ent_we    = 1'b1;
          ent_waddr = prev[EW-1:0];
          ent_wdata = {pw[WW-1:LW], rd_next};
        end
        WE_DETACH: begin
          ent_we    = 1'b1;
          ent_wdata = {cur[WW-1:LW], NIL};
        end
        default: ent_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = bidx;
    bkt_wdata = hlink;
    if (cmd.clr_step) begin
      bkt_we    = ({{(32-CW){1'b0}}, clr_cnt} < 32'(BUCKETS));
      bkt_waddr = clr_cnt[BW-1:0];
      bkt_wdata = NIL;
    end else begin
      unique case (cmd.bkt_wr)
        BK_INSERT: bkt_we = 1'b1;
        BK_UNLINK: begin
          bkt_we    = 1'b1;
          bkt_wdata = rd_next;
        end
        default: bkt_we = 1'b0;
      endcase
    end
  end

  uhnt_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  uhnt_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bidx),
    .rdata (bkt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      clr_done     <= 1'b0;
      serial_count <= 32'd0;
      local_node   <= 16'd0;
      id_base      <= ID_BASE_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        if (clr_cnt == CLR_LAST) begin
          clr_done <= 1'b1;
        end else begin
          clr_cnt <= clr_cnt + CW'(1);
        end
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_LOCAL_NODE) begin
          local_node <= cfg_data[15:0];
        end else begin
          id_base <= cfg_data;
        end
      end
      if (cmd.key_alloc) begin
        serial_count <= s_new;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= op;
      h_q   <= port_handle;
      org_q <= uid_origin;
      ser_q <= uid_serial;
    end
    if (cmd.key_alloc) begin
      org_q <= local_node;
      ser_q <= s_new;
    end
    if (cmd.key_entry) begin
      org_q <= rd_org;
      ser_q <= rd_ser;
    end
    if (cmd.keep_cur) begin
      cur <= ent_rdata;
    end
    if (cmd.walk_start) begin
      head  <= bkt_rdata;
      p     <= bkt_rdata;
      prev  <= NIL;
      steps <= '0;
    end
    if (cmd.walk_adv) begin
      prev  <= p;
      pw    <= ent_rdata;
      p     <= rd_next;
      steps <= steps + LW'(1);
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_found  <= cmd.res_found ? p_wide[7:0] : 8'd0;
      res_given  <= cmd.res_given ? ser_q : 32'd0;
    end
    if (cmd.out_load) begin
      status          <= res_status;
      found_handle    <= res_found;
      assigned_serial <= res_given;
    end
  end

  always_comb begin
    sts.clr_done     = clr_done;
    sts.op           = op_q;
    sts.h_ok         = ({24'd0, h_q} < 32'(ENTRIES));
    sts.key_zero     = (ser_q == 32'd0);
    sts.cur_assigned = (rd_ser != 32'd0);
    sts.cur_inuse    = (rd_refs != 16'd0);
    sts.walk_end     = (p >= NIL) || (steps >= LW'(ENTRIES));
    sts.match        = (op_q == OP_REMOVE) ? (p == hlink)
                                           : ((rd_org == org_q) && (rd_ser == ser_q));
    sts.prev_nil     = (prev == NIL);
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

[sv/uhnt_ctrl.sv]
// ----------------------------------------------------------------------------
// uhnt_ctrl
// Controller: sequences the clearing sweep, entry checks, chain walks,
// table updates and result delivery for one operation at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module uhnt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire uhnt_pkg::dp_sts_t sts,
  output uhnt_pkg::dp_cmd_t      cmd
);

  import uhnt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.ent_wr = WE_NONE;
    cmd.bkt_wr = BK_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.op == OP_LOOKUP) begin
          if (sts.key_zero) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_NOTFOUND;
            state_next     = S_FIN;
          end else begin
            state_next = S_BRD;
          end
        end else if (!sts.h_ok || sts.op > OP_RELEASE) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_next     = S_FIN;
        end else begin
          state_next = S_HCHK;
        end
      end
      S_HCHK: begin
        cmd.keep_cur = 1'b1;
        case (sts.op)
          OP_ALLOC: begin
            if (sts.cur_assigned) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_DUP;
              state_next     = S_FIN;
            end else begin
              cmd.key_alloc = 1'b1;
              state_next    = S_BRD;
            end
          end
          OP_INSTALL: begin
            if (sts.cur_assigned) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_DUP;
              state_next     = S_FIN;
            end else if (sts.key_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_next     = S_FIN;
            end else begin
              state_next = S_BRD;
            end
          end
          OP_REMOVE: begin
            if (sts.cur_inuse) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_INUSE;
              state_next     = S_FIN;
            end else if (!sts.cur_assigned) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_OK;
              state_next     = S_FIN;
            end else begin
              cmd.key_entry = 1'b1;
              state_next    = S_BRD;
            end
          end
          default: begin
            cmd.ent_wr     = WE_RELEASE;
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_FIN;
          end
        endcase
      end
      S_BRD: begin
        state_next = S_BHEAD;
      end
      S_BHEAD: begin
        cmd.walk_start = 1'b1;
        state_next     = (sts.op == OP_ALLOC) ? S_INS : S_WSTEP;
      end
      S_WSTEP: begin
        cmd.rd_p = 1'b1;
        if (sts.walk_end) begin
          if (sts.op == OP_INSTALL) begin
            state_next = S_INS;
          end else begin
            cmd.set_res    = 1'b1;
            cmd.res_status = (sts.op == OP_LOOKUP) ? ST_NOTFOUND : ST_OK;
            state_next     = S_FIN;
          end
        end else begin
          state_next = S_WCMP;
        end
      end
      S_WCMP: begin
        if (sts.match) begin
          if (sts.op == OP_INSTALL) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_DUP;
            state_next     = S_FIN;
          end else if (sts.op == OP_LOOKUP) begin
            cmd.ent_wr     = WE_LOOKUP;
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_found  = 1'b1;
            state_next     = S_FIN;
          end else begin
            if (sts.prev_nil) begin
              cmd.bkt_wr = BK_UNLINK;
            end else begin
              cmd.ent_wr = WE_PREV;
            end
            state_next = S_DETACH;
          end
        end else begin
          cmd.walk_adv = 1'b1;
          state_next   = S_WSTEP;
        end
      end
      S_INS: begin
        cmd.ent_wr     = WE_INSERT;
        cmd.bkt_wr     = BK_INSERT;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_given  = (sts.op == OP_ALLOC);
        state_next     = S_FIN;
      end
      S_DETACH: begin
        cmd.ent_wr     = WE_DETACH;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_cmp_after_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WCMP) |-> ($past(state) == S_WSTEP))
    else $error("chain compare without a preceding entry read");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && sts.out_free) |=> (state == S_IDLE))
    else $error("result delivered but controller did not return to idle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_CLEAR) |-> (cmd.ent_wr == WE_NONE && cmd.bkt_wr == BK_NONE))
    else $error("table update outside an operation");

  a_clear_before_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> sts.clr_done)
    else $error("word taken before the clearing sweep finished");

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hashed identifier table: a directed table of
// operations, then random traffic with live identifiers, checked word by word
// against a behavioral table model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import uhnt_pkg::*;

  localparam int NENT = 256;
  localparam int NBKT = 1024;
  localparam int NIL  = NENT;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  hnd;
    logic [15:0] org;
    logic [31:0] ser;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [7:0]  fnd;
    logic [31:0] given;
  } answer_t;

  typedef struct {
    cmd_t    c;
    logic    chk;
    answer_t a;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = '0;
  logic [7:0]  port_handle = '0;
  logic [15:0] uid_origin = '0;
  logic [31:0] uid_serial = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  found_handle;
  logic [31:0] assigned_serial;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  uid_hash_name_table u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .port_handle(port_handle), .uid_origin(uid_origin),
    .uid_serial(uid_serial),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_handle(found_handle),
    .assigned_serial(assigned_serial),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // table model
  logic [15:0] node_q;
  logic [31:0] base_q;
  int          head_q [NBKT];
  logic [15:0] org_q [NENT];
  logic [31:0] ser_q [NENT];
  int          next_q [NENT];
  logic [15:0] refs_q [NENT];
  logic [31:0] count_q;

  answer_t answers_q[$];
  int      errors = 0;
  int      hold_cycles = 0;
  logic    out_pause = 1'b0;

  function automatic int bucket_of(logic [15:0] o, logic [31:0] s);
    logic [31:0] sum;
    sum = {16'd0, o} + s;
    return int'(sum[9:0]);
  endfunction

  function automatic int find_id(logic [15:0] o, logic [31:0] s);
    int p;
    int n;
    p = head_q[bucket_of(o, s)];
    n = 0;
    while (p < NIL && n < NENT) begin
      if (org_q[p] == o && ser_q[p] == s) return p;
      p = next_q[p];
      n++;
    end
    return NIL;
  endfunction

  function automatic void link_head(int h);
    int b;
    b = bucket_of(org_q[h], ser_q[h]);
    next_q[h] = head_q[b];
    head_q[b] = h;
  endfunction

  function automatic void unlink(int h);
    int b;
    int prv;
    int p;
    int n;
    b = bucket_of(org_q[h], ser_q[h]);
    prv = NIL;
    p = head_q[b];
    n = 0;
    while (p < NIL && n < NENT) begin
      if (p == h) begin
        if (prv == NIL) head_q[b] = next_q[p];
        else next_q[prv] = next_q[p];
        next_q[p] = NIL;
        return;
      end
      prv = p;
      p = next_q[p];
      n++;
    end
  endfunction

  function automatic void table_clear();
    node_q = '0;
    base_q = ID_BASE_RESET;
    count_q = '0;
    foreach (head_q[i]) head_q[i] = NIL;
    for (int i = 0; i < NENT; i++) begin
      org_q[i] = '0;
      ser_q[i] = '0;
      next_q[i] = NIL;
      refs_q[i] = '0;
    end
  endfunction

  function automatic answer_t table_apply(cmd_t c);
    answer_t a;
    int h;
    int p;
    logic [31:0] s;
    a = '{ST_NOTFOUND, 8'd0, 32'd0};
    h = int'(c.hnd);
    case (c.op)
      OP_ALLOC: begin
        if (ser_q[h] != 0) a.st = ST_DUP;
        else begin
          s = (count_q > base_q ? count_q : base_q) + 32'd1;
          if (s == 0) s = 32'd1;
          count_q = s;
          org_q[h] = node_q;
          ser_q[h] = s;
          link_head(h);
          a.st = ST_OK;
          a.given = s;
        end
      end
      OP_INSTALL: begin
        if (ser_q[h] != 0) a.st = ST_DUP;
        else if (c.ser == 0) a.st = ST_NOTFOUND;
        else if (find_id(c.org, c.ser) != NIL) a.st = ST_DUP;
        else begin
          org_q[h] = c.org;
          ser_q[h] = c.ser;
          link_head(h);
          a.st = ST_OK;
        end
      end
      OP_LOOKUP: begin
        p = (c.ser == 0) ? NIL : find_id(c.org, c.ser);
        if (p != NIL) begin
          if (refs_q[p] != 16'hFFFF) refs_q[p]++;
          a.fnd = p[7:0];
          a.st = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (refs_q[h] != 0) a.st = ST_INUSE;
        else begin
          if (ser_q[h] != 0) unlink(h);
          a.st = ST_OK;
        end
      end
      OP_RELEASE: begin
        if (refs_q[h] != 0) refs_q[h]--;
        a.st = ST_OK;
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (answers_q.size() == 0) report("unexpected word", 64'd0, 64'd0);
      else begin
        answer_t w;
        w = answers_q.pop_front();
        if (status != w.st) report("status", 64'(status), 64'(w.st));
        if (found_handle != w.fnd)
          report("found_handle", 64'(found_handle), 64'(w.fnd));
        if (assigned_serial != w.given)
          report("assigned_serial", 64'(assigned_serial), 64'(w.given));
      end
    end
  end

  // receiver
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = out_pause ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send(cmd_t c, logic chk, answer_t want, logic no_gap);
    answer_t a;
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op = c.op;
    port_handle = c.hnd;
    uid_origin = c.org;
    uid_serial = c.ser;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    a = table_apply(c);
    if (chk && a != want) report("table row", 64'(a), 64'(want));
    answers_q.push_back(a);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (answers_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LOCAL_NODE) node_q = v[15:0];
    else base_q = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic cmd_t rand_cmd(int live_pct);
    cmd_t c;
    int r;
    int k;
    c.op = 3'($urandom_range(0, 4));
    if ($urandom_range(0, 39) == 0) c.op = 3'($urandom_range(5, 7));
    c.hnd = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
    c.org = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r = $urandom_range(0, 9);
    c.ser = (r < 2) ? 32'($urandom_range(0, 8))
          : (r == 2 ? 32'hFFFF_FFFF - 32'($urandom_range(0, 3)) : $urandom);
    if (c.op != OP_ALLOC && $urandom_range(0, 99) < live_pct) begin
      k = $urandom_range(0, NENT - 1);
      for (int i = 0; i < NENT; i++) begin
        if (ser_q[(k + i) % NENT] != 0) begin
          k = (k + i) % NENT;
          c.org = org_q[k];
          c.ser = ser_q[k];
          if (c.op != OP_LOOKUP) c.hnd = 8'(k);
          break;
        end
      end
    end
    return c;
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(logic [2:0] o, logic [7:0] h, logic [15:0] g,
                                  logic [31:0] s, logic chk, logic [1:0] st,
                                  logic [7:0] f, logic [31:0] gv);
    row_t r;
    r.c = '{o, h, g, s};
    r.chk = chk;
    r.a = '{st, f, gv};
    dir_rows.push_back(r);
  endfunction

  initial begin
    cmd_t c;
    table_clear();
    add_row(OP_LOOKUP,  8'd0,   16'd0,     32'd0,          1, ST_NOTFOUND, 0, 0);
    add_row(OP_ALLOC,   8'd0,   16'd0,     32'd0,          1, ST_OK, 0, 32'd101);
    add_row(OP_ALLOC,   8'd0,   16'd0,     32'd0,          1, ST_DUP, 0, 0);
    add_row(OP_ALLOC,   8'd255, 16'd0,     32'd0,          1, ST_OK, 0, 32'd102);
    add_row(OP_INSTALL, 8'd1,   16'hFFFF,  32'hFFFF_FFFF,  1, ST_OK, 0, 0);
    add_row(OP_INSTALL, 8'd2,   16'hFFFF,  32'hFFFF_FFFF,  1, ST_DUP, 0, 0);
    add_row(OP_INSTALL, 8'd2,   16'h1234,  32'd0,          1, ST_NOTFOUND, 0, 0);
    add_row(OP_INSTALL, 8'd1,   16'd5,     32'd5,          1, ST_DUP, 0, 0);
    add_row(OP_INSTALL, 8'd3,   16'd0,     32'd1022,       0, 0, 0, 0);
    add_row(OP_INSTALL, 8'd4,   16'd1,     32'd1021,       0, 0, 0, 0);
    add_row(OP_LOOKUP,  8'd0,   16'hFFFF,  32'hFFFF_FFFF,  1, ST_OK, 8'd1, 0);
    add_row(OP_LOOKUP,  8'd0,   16'd0,     32'd1022,       0, 0, 0, 0);
    add_row(OP_REMOVE,  8'd1,   16'd0,     32'd0,          1, ST_INUSE, 0, 0);
    add_row(OP_RELEASE, 8'd1,   16'd0,     32'd0,          1, ST_OK, 0, 0);
    add_row(OP_RELEASE, 8'd1,   16'd0,     32'd0,          1, ST_OK, 0, 0);
    add_row(OP_REMOVE,  8'd1,   16'd0,     32'd0,          1, ST_OK, 0, 0);
    add_row(OP_REMOVE,  8'd1,   16'd0,     32'd0,          1, ST_OK, 0, 0);
    add_row(OP_LOOKUP,  8'd0,   16'hFFFF,  32'hFFFF_FFFF,  1, ST_NOTFOUND, 0, 0);
    add_row(OP_REMOVE,  8'd4,   16'd0,     32'd0,          0, 0, 0, 0);
    add_row(OP_REMOVE,  8'd9,   16'd0,     32'd0,          1, ST_OK, 0, 0);
    add_row(OP_LOOKUP,  8'd0,   16'd0,     32'd1022,       0, 0, 0, 0);
    add_row(3'd5,       8'd0,   16'd0,     32'd0,          1, ST_NOTFOUND, 0, 0);
    add_row(3'd7,       8'hAA,  16'hAAAA,  32'hAAAA_AAAA,  1, ST_NOTFOUND, 0, 0);

    repeat (8) @(negedge clk);
    rst = 1'b0;
    foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].chk, dir_rows[i].a, 1'b0);
    drain();

    // extremes of both registers; the serial counter wraps past zero
    write_reg(CFG_LOCAL_NODE, 32'h0000_FFFF);
    write_reg(CFG_ID_BASE, 32'hFFFF_FFFE);
    send('{OP_ALLOC, 8'd10, 16'd0, 32'd0}, 1, '{ST_OK, 8'd0, 32'hFFFF_FFFF}, 1'b0);
    send('{OP_ALLOC, 8'd11, 16'd0, 32'd0}, 1, '{ST_OK, 8'd0, 32'd1}, 1'b0);
    drain();
    write_reg(CFG_ID_BASE, 32'd0);
    write_reg(CFG_LOCAL_NODE, 32'h0000_0000);

    // release floor on an entry with no references
    for (int i = 0; i < 3; i++) send('{OP_RELEASE, 8'd20, 16'd0, 32'd0}, 0, '0, 1'b0);

    for (int n = 0; n < 650; n++) begin
      if (n == 150 || n == 400) begin
        drain();
        write_reg(CFG_LOCAL_NODE, $urandom);
        write_reg(CFG_ID_BASE, $urandom_range(0, 1000) * (n == 400 ? 4000000 : 1));
      end
      if (n == 250) hold_cycles = 300;
      if (n == 500) begin
        out_pause = 1'b1;
        drain();
        out_pause = 1'b0;
      end
      c = rand_cmd(55);
      send(c, 0, '0, ($urandom_range(0, 3) == 0) || (n >= 300 && n < 360));
    end
    drain();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/uhnt_pkg.sv
sv/uhnt_ram.sv
sv/uhnt_dp.sv
sv/uhnt_ctrl.sv
sv/uid_hash_name_table.sv
test/tb_top.sv
